// ----- hdl/ple_pkg.sv -----
// ple_pkg: shared types, codes and constants for the positional list engine.
// No dependencies; every other file imports it.
`default_nettype none

package ple_pkg;

   // Field widths fixed by the channel formats
   localparam int CMD_W      = 3;
   localparam int VALUE_W    = 32;
   localparam int POS_W      = 8;
   localparam int STATUS_W   = 2;
   localparam int COUNT_W    = 5;

   // Default list capacity
   localparam int DEPTH_DEF  = 16;

   // Command codes (codes 6 and 7 are unused and act as no-ops)
   typedef enum logic [CMD_W-1:0] {
      CMD_INS_FIRST = 3'd0,
      CMD_INS_LAST  = 3'd1,
      CMD_DEL_FIRST = 3'd2,
      CMD_DEL_LAST  = 3'd3,
      CMD_INS_AT    = 3'd4,
      CMD_DEL_AT    = 3'd5
   } cmd_type;

   // Result status codes
   typedef enum logic [STATUS_W-1:0] {
      STS_OK     = 2'd0,
      STS_BADPOS = 2'd1,
      STS_FULL   = 2'd2,
      STS_EMPTY  = 2'd3
   } status_type;

   // Controller states
   typedef enum logic {
      FSM_IDLE = 1'b0,
      FSM_EXEC = 1'b1
   } fsm_type;

   // Controller to datapath commands
   typedef struct packed {
      logic load;   // capture the request payload
      logic exec;   // apply the command and load the result register
   } ctl_type;

endpackage

`default_nettype wire

// ----- hdl/ple_channels.sv -----
// ple_channels: valid/ready channel interfaces for requests and results.
// Depends on ple_pkg for the field widths.
`default_nettype none

interface ple_req_if
   import ple_pkg::*;
   ();
   logic                      valid;
   logic                      ready;
   logic [CMD_W-1:0]          cmd;
   logic signed [VALUE_W-1:0] value;
   logic [POS_W-1:0]          position;

   modport source (output valid, output cmd, output value, output position, input ready);
   modport sink   (input valid, input cmd, input value, input position, output ready);
endinterface

interface ple_rsp_if
   import ple_pkg::*;
   ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [COUNT_W-1:0]  count;

   modport source (output valid, output status, output count, input ready);
   modport sink   (input valid, input status, input count, output ready);
endinterface

`default_nettype wire

// ----- hdl/ple_ctrl.sv -----
// ple_ctrl: two-state sequencer (accept, execute) and result valid flag.
// Depends on ple_pkg.
`default_nettype none

module ple_ctrl
   import ple_pkg::*;
(
   input  wire     clock,
   input  wire     reset,
   input  wire     req_valid,
   output logic    req_ready,
   input  wire     rsp_ready,
   output logic    rsp_valid,
   output ctl_type ctl
);

   fsm_type state_ff, state_in;
   logic    rsp_valid_ff, rsp_valid_in;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         FSM_IDLE: begin
            if (req_valid) state_in = FSM_EXEC;
         end
         FSM_EXEC: begin
            if (!rsp_valid_ff || rsp_ready) state_in = FSM_IDLE;
         end
         default: state_in = FSM_IDLE;
      endcase
   end

   // Outputs: execute only once the result register can take a new result
   always_comb begin
      req_ready = 1'b0;
      ctl.load  = 1'b0;
      ctl.exec  = 1'b0;
      case (state_ff)
         FSM_IDLE: begin
            req_ready = 1'b1;
            ctl.load  = req_valid;
         end
         FSM_EXEC: begin
            ctl.exec = !rsp_valid_ff || rsp_ready;
         end
         default: ;
      endcase
   end

   // Result valid: set on execute, cleared when the transfer completes
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (ctl.exec)       rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FSM_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef SYNTH
   // A pending result is never overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |-> !ctl.exec)
      else $error("result overwritten while pending");

   // Every accepted request takes the controller to the execute state in a following cycle
   a_load_then_exec: assert property (@(posedge clock) disable iff (reset)
      ctl.load |=> (state_ff == FSM_EXEC))
      else $error("accepted request not taken to execute");

   // No request is taken while one is being executed
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (state_ff == FSM_EXEC) |-> (!req_ready && !ctl.load))
      else $error("request accepted during execute");
`endif

endmodule

`default_nettype wire

// ----- hdl/ple_dpath.sv -----
// ple_dpath: request register, command decode, shifting entry register file,
// occupancy counter and result register. Depends on ple_pkg.
`default_nettype none

module ple_dpath
   import ple_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEF
) (
   input  wire                        clock,
   input  wire                        reset,
   input  ctl_type                    ctl,
   input  wire [CMD_W-1:0]            req_cmd,
   input  wire signed [VALUE_W-1:0]   req_value,
   input  wire [POS_W-1:0]            req_position,
   output logic [STATUS_W-1:0]        rsp_status,
   output logic [COUNT_W-1:0]         rsp_count
);

   localparam int OW   = $clog2(DEPTH + 1);   // occupancy width
   localparam int IW   = $clog2(DEPTH);       // slot index width
   localparam int CMPW = POS_W + 1;           // position compare width

   // Captured request
   logic [CMD_W-1:0]          cmd_ff;
   logic signed [VALUE_W-1:0] value_ff;
   logic [POS_W-1:0]          pos_ff;

   // List state
   logic [VALUE_W-1:0] entries_ff [DEPTH];
   logic [VALUE_W-1:0] entries_in [DEPTH];
   logic [OW-1:0]      occ_ff, occ_in;

   // Result register
   logic [STATUS_W-1:0] status_ff;
   logic [COUNT_W-1:0]  count_ff;

   // Decode
   status_type      sts;
   logic            do_ins, do_del;
   logic [CMPW-1:0] slot_x, pos_x, occ_x;
   logic [IW-1:0]   slot;
   logic            full, empty;

   assign full  = (occ_ff == OW'(DEPTH));
   assign empty = (occ_ff == '0);
   assign pos_x = CMPW'(pos_ff);
   assign occ_x = CMPW'(occ_ff);
   assign slot  = slot_x[IW-1:0];

   // Command decode: status, operation and target slot
   always_comb begin
      sts    = STS_OK;
      do_ins = 1'b0;
      do_del = 1'b0;
      slot_x = '0;
      case (cmd_ff)
         CMD_INS_FIRST: begin
            if (full) sts = STS_FULL;
            else do_ins = 1'b1;
         end
         CMD_INS_LAST: begin
            slot_x = occ_x;
            if (full) sts = STS_FULL;
            else do_ins = 1'b1;
         end
         CMD_DEL_FIRST: begin
            if (empty) sts = STS_EMPTY;
            else do_del = 1'b1;
         end
         CMD_DEL_LAST: begin
            slot_x = occ_x - CMPW'(1);
            if (empty) sts = STS_EMPTY;
            else do_del = 1'b1;
         end
         CMD_INS_AT: begin
            slot_x = pos_x - CMPW'(1);
            if (pos_x == '0 || pos_x > occ_x + CMPW'(1)) sts = STS_BADPOS;
            else if (full) sts = STS_FULL;
            else do_ins = 1'b1;
         end
         CMD_DEL_AT: begin
            slot_x = pos_x - CMPW'(1);
            if (empty) sts = STS_EMPTY;
            else if (pos_x == '0 || pos_x > occ_x) sts = STS_BADPOS;
            else do_del = 1'b1;
         end
         default: ;
      endcase
   end

   // Parallel shift: each entry looks only at its neighbors
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         entries_in[i] = entries_ff[i];
         if (do_ins) begin
            if (IW'(i) == slot) entries_in[i] = value_ff;
            else if (i > 0 && IW'(i) > slot && OW'(i) <= occ_ff)
               entries_in[i] = entries_ff[(i > 0) ? i - 1 : 0];
         end else if (do_del) begin
            if (i < DEPTH - 1 && IW'(i) >= slot && OW'(i + 1) < occ_ff)
               entries_in[i] = entries_ff[(i < DEPTH - 1) ? i + 1 : i];
         end
      end
   end

   // Occupancy update
   always_comb begin
      occ_in = occ_ff;
      if (do_ins)      occ_in = occ_ff + OW'(1);
      else if (do_del) occ_in = occ_ff - OW'(1);
   end

   // Request capture
   always_ff @(posedge clock) begin
      if (ctl.load) begin
         cmd_ff   <= req_cmd;
         value_ff <= req_value;
         pos_ff   <= req_position;
      end
   end

   // Entries carry no reset
   always_ff @(posedge clock) begin
      if (ctl.exec) entries_ff <= entries_in;
   end

   always_ff @(posedge clock) begin
      if (reset) occ_ff <= '0;
      else if (ctl.exec) occ_ff <= occ_in;
   end

   // Result register
   always_ff @(posedge clock) begin
      if (ctl.exec) begin
         status_ff <= sts;
         count_ff  <= COUNT_W'(occ_in);
      end
   end

   assign rsp_status = status_ff;
   assign rsp_count  = count_ff;

`ifndef SYNTH
   // Occupancy stays within capacity
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= OW'(DEPTH))
      else $error("occupancy above capacity");

   // A rejected command leaves the count alone
   a_reject_hold: assert property (@(posedge clock) disable iff (reset)
      (ctl.exec && sts != STS_OK) |=> (occ_ff == $past(occ_ff)))
      else $error("rejected command changed occupancy");

   // Insert and delete are never both decoded
   a_one_op: assert property (@(posedge clock) disable iff (reset)
      ctl.exec |-> !(do_ins && do_del))
      else $error("insert and delete decoded together");
`endif

endmodule

`default_nettype wire

// ----- hdl/positional_list_engine.sv -----
// A request is captured in the request register on transfer; in the execute state its result
// is loaded into the result register, and execute waits while the previous result is still
// waiting to be read. Commands go one at a time through the controller's accept/execute
// sequence; a new request is taken while the previous result waits to be read.
// Each accepted insert or delete shifts entries in parallel in its execute cycle.
// Reset (synchronous): empties the list and drops any pending result;
// entry contents are undefined until written.
`default_nettype none

module positional_list_engine
   import ple_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEF
) (
   input  wire       clock,
   input  wire       reset,
   ple_req_if.sink   req_chan,
   ple_rsp_if.source rsp_chan
);

   ctl_type ctl;

   ple_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_ready (rsp_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .ctl       (ctl)
   );

   ple_dpath #(
      .DEPTH (DEPTH)
   ) u_dpath (
      .clock        (clock),
      .reset        (reset),
      .ctl          (ctl),
      .req_cmd      (req_chan.cmd),
      .req_value    (req_chan.value),
      .req_position (req_chan.position),
      .rsp_status   (rsp_chan.status),
      .rsp_count    (rsp_chan.count)
   );

endmodule

`default_nettype wire

// ----- sim/tb_positional_list_engine.sv -----
// tb_positional_list_engine: self-checking bench for the positional list engine.
// Depends on ple_pkg, ple_channels (ple_req_if, ple_rsp_if) and positional_list_engine.
// Directed table, then biased random commands; checked against a shadow list or typed rows' answers.
`default_nettype none

module tb_positional_list_engine;
   import ple_pkg::*;

   // Unused command codes, accepted as no-ops
   localparam logic [CMD_W-1:0] CMD_UNUSED6 = 3'd6;
   localparam logic [CMD_W-1:0] CMD_UNUSED7 = 3'd7;

   localparam int RANDOM_ITEMS = 1600;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 8;
   localparam int LIMIT_CYCLES = 400000;

   typedef struct {
      status_type         status;
      logic [COUNT_W-1:0] count;
   } list_rsp;

   // One row of the directed table; typed rows carry their own answer
   typedef struct {
      logic [CMD_W-1:0]          op;
      logic signed [VALUE_W-1:0] val;
      logic [POS_W-1:0]          pos;
      int                        reps;
      bit                        typed;
      status_type                st;
      logic [COUNT_W-1:0]        cnt;
   } dir_row;

   localparam int DIR_ROWS = 22;

   dir_row dir_table [DIR_ROWS] = '{
      // empty list: deletes report empty, even with a bad position
      '{CMD_DEL_FIRST, 32'h0000_0000, 8'd0,   1, 1'b1, STS_EMPTY,  5'd0},
      '{CMD_DEL_AT,    32'h0000_0000, 8'd1,   1, 1'b1, STS_EMPTY,  5'd0},
      '{CMD_DEL_AT,    32'h0000_0000, 8'd0,   1, 1'b1, STS_EMPTY,  5'd0},
      // insert-at position checks on an empty list
      '{CMD_INS_AT,    32'h1234_5678, 8'd0,   1, 1'b1, STS_BADPOS, 5'd0},
      '{CMD_INS_AT,    32'h1234_5678, 8'd2,   1, 1'b1, STS_BADPOS, 5'd0},
      // value extremes
      '{CMD_INS_AT,    32'h8000_0000, 8'd1,   1, 1'b1, STS_OK,     5'd1},
      '{CMD_INS_FIRST, 32'h7FFF_FFFF, 8'd0,   1, 1'b1, STS_OK,     5'd2},
      '{CMD_INS_LAST,  32'hFFFF_FFFF, 8'd255, 1, 1'b1, STS_OK,     5'd3},
      // unused codes leave the count alone
      '{CMD_UNUSED6,   32'hFFFF_FFFF, 8'd255, 1, 1'b1, STS_OK,     5'd3},
      '{CMD_UNUSED7,   32'h0000_0000, 8'd0,   1, 1'b1, STS_OK,     5'd3},
      // position checks on a non-empty list: out-of-range delete-at and insert-at, then in-range ones
      '{CMD_DEL_AT,    32'h0000_0000, 8'd4,   1, 1'b1, STS_BADPOS, 5'd3},
      '{CMD_DEL_AT,    32'h0000_0000, 8'd255, 1, 1'b1, STS_BADPOS, 5'd3},
      '{CMD_INS_AT,    32'h0000_0000, 8'd255, 1, 1'b1, STS_BADPOS, 5'd3},
      '{CMD_DEL_AT,    32'h0000_0000, 8'd2,   1, 1'b0, STS_OK,     5'd0},
      '{CMD_INS_AT,    32'h0000_0000, 8'd3,   1, 1'b0, STS_OK,     5'd0},
      // fill to capacity
      '{CMD_INS_LAST,  32'h5A5A_0000, 8'd0,  13, 1'b0, STS_OK,     5'd0},
      // full list: inserts rejected, position check wins over full
      '{CMD_INS_FIRST, 32'h0000_0001, 8'd0,   1, 1'b1, STS_FULL,   5'd16},
      '{CMD_INS_AT,    32'h0000_0001, 8'd17,  1, 1'b1, STS_FULL,   5'd16},
      '{CMD_INS_AT,    32'h0000_0001, 8'd18,  1, 1'b1, STS_BADPOS, 5'd16},
      '{CMD_DEL_AT,    32'h0000_0000, 8'd16,  1, 1'b0, STS_OK,     5'd0},
      '{CMD_DEL_FIRST, 32'h0000_0000, 8'd0,   1, 1'b0, STS_OK,     5'd0},
      '{CMD_DEL_LAST,  32'h0000_0000, 8'd0,   1, 1'b0, STS_OK,     5'd0}
   };

   logic clock = 1'b0;
   logic reset;

   ple_req_if req_bus ();
   ple_rsp_if rsp_bus ();

   positional_list_engine i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   // Shadow of the list contents and the results still owed
   logic signed [VALUE_W-1:0] shadow_list [$];
   list_rsp                   pending_rsp [$];

   int          mismatch_count = 0;
   int unsigned cycle_count    = 0;
   int          burst_left     = 0;
   bit          grow_bias      = 1'b1;
   bit          rsp_hold_req   = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Apply one command to the shadow list and return the result it owes
   function automatic list_rsp apply_list_command(logic [CMD_W-1:0] op,
                                                  logic signed [VALUE_W-1:0] val,
                                                  logic [POS_W-1:0] pos);
      list_rsp r;
      int      fill;
      fill     = shadow_list.size();
      r.status = STS_OK;
      case (op)
         CMD_INS_FIRST, CMD_INS_LAST: begin
            if (fill >= DEPTH_DEF) r.status = STS_FULL;
            else if (op == CMD_INS_FIRST) shadow_list.push_front(val);
            else shadow_list.push_back(val);
         end
         CMD_DEL_FIRST, CMD_DEL_LAST: begin
            if (fill == 0) r.status = STS_EMPTY;
            else if (op == CMD_DEL_FIRST) void'(shadow_list.pop_front());
            else void'(shadow_list.pop_back());
         end
         CMD_INS_AT: begin
            if (pos < 1 || pos > fill + 1) r.status = STS_BADPOS;
            else if (fill >= DEPTH_DEF) r.status = STS_FULL;
            else shadow_list.insert(int'(pos) - 1, val);
         end
         CMD_DEL_AT: begin
            if (fill == 0) r.status = STS_EMPTY;
            else if (pos < 1 || pos > fill) r.status = STS_BADPOS;
            else shadow_list.delete(int'(pos) - 1);
         end
         default: ;
      endcase
      r.count = COUNT_W'(shadow_list.size());
      return r;
   endfunction

   task automatic report_mismatch(string what, int unsigned want, int unsigned got);
      mismatch_count++;
      $display("[%0t] mismatch on %s: expected %0d, got %0d", $time, what, want, got);
   endtask

   // Offer one command and hold it until the transfer; then log its result
   task automatic push_command(logic [CMD_W-1:0] op, logic signed [VALUE_W-1:0] val,
                               logic [POS_W-1:0] pos, bit typed, list_rsp typed_rsp);
      list_rsp predicted;
      req_bus.valid    <= 1'b1;
      req_bus.cmd      <= op;
      req_bus.value    <= val;
      req_bus.position <= pos;
      do @(posedge clock); while (!req_bus.ready);
      predicted = apply_list_command(op, val, pos);
      pending_rsp.push_back(typed ? typed_rsp : predicted);
   endtask

   // Burst pacing: after a burst, drop valid for a random gap
   task automatic pace_sender();
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = $urandom_range(0, 30);
      end
   endtask

   // Stop offering until every owed result has come back
   task automatic wait_results_drained();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (pending_rsp.size() != 0);
   endtask

   // Random command, biased to sweep the list between empty and full
   task automatic pick_random_command(output logic [CMD_W-1:0] op,
                                      output logic signed [VALUE_W-1:0] val,
                                      output logic [POS_W-1:0] pos);
      int fill;
      int pick;
      int pos_kind;
      fill = shadow_list.size();
      if (fill >= DEPTH_DEF) grow_bias = 1'b0;
      else if (fill == 0) grow_bias = 1'b1;
      else if ($urandom_range(0, 40) == 0) grow_bias = !grow_bias;

      pick = $urandom_range(0, 99);
      if (pick < 3) begin
         op = pick[0] ? CMD_UNUSED7 : CMD_UNUSED6;
      end else if (pick < (grow_bias ? 68 : 35)) begin
         case ($urandom_range(0, 2))
            0:       op = CMD_INS_FIRST;
            1:       op = CMD_INS_LAST;
            default: op = CMD_INS_AT;
         endcase
      end else begin
         case ($urandom_range(0, 2))
            0:       op = CMD_DEL_FIRST;
            1:       op = CMD_DEL_LAST;
            default: op = CMD_DEL_AT;
         endcase
      end

      case ($urandom_range(0, 7))
         0:       val = 32'h8000_0000;
         1:       val = 32'h7FFF_FFFF;
         2:       val = 32'hFFFF_FFFF;
         default: val = $urandom;
      endcase

      // mostly in-range positions, some edges, some anything
      pos_kind = $urandom_range(0, 9);
      if (pos_kind == 0) begin
         pos = POS_W'($urandom_range(0, 255));
      end else if (pos_kind == 1) begin
         case ($urandom_range(0, 3))
            0:       pos = 8'd0;
            1:       pos = POS_W'(fill + 1);
            2:       pos = POS_W'(fill + 2);
            default: pos = 8'd255;
         endcase
      end else if (op == CMD_INS_AT) begin
         pos = POS_W'($urandom_range(1, fill + 1));
      end else if (op == CMD_DEL_AT) begin
         pos = POS_W'($urandom_range(1, (fill > 0) ? fill : 1));
      end else begin
         pos = POS_W'($urandom_range(0, 255));
      end
   endtask

   // Receiver: stall pattern that changes mode, plus an on-demand long hold
   initial begin : rsp_stall_gen
      int               mode;
      int               mode_left;
      int               hold_left;
      logic [7:0]       stall_mask;
      mode       = 0;
      mode_left  = 0;
      hold_left  = 0;
      stall_mask = 8'hFF;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_hold_req) begin
            rsp_hold_req = 1'b0;
            hold_left    = HOLD_CYCLES;
         end
         if (mode_left == 0) begin
            mode       = $urandom_range(0, 3);
            mode_left  = $urandom_range(20, 200);
            stall_mask = 8'($urandom_range(1, 255));
         end
         mode_left--;
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            case (mode)
               0:       rsp_bus.ready <= 1'b1;
               1:       rsp_bus.ready <= 1'($urandom_range(0, 1));
               2:       rsp_bus.ready <= stall_mask[mode_left % 8];
               default: rsp_bus.ready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   // Result checker: each transfer against the oldest owed result
   always @(posedge clock) begin : rsp_check
      list_rsp want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_rsp.size() == 0) begin
            report_mismatch("result with nothing pending (count)", 0, rsp_bus.count);
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_bus.status !== want.status)
               report_mismatch("status", want.status, rsp_bus.status);
            if (rsp_bus.count !== want.count)
               report_mismatch("count", want.count, rsp_bus.count);
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("FAIL");
         $finish;
      end
   end

   // Main sequence: reset, directed table, random traffic, drain
   initial begin : stimulus
      logic [CMD_W-1:0]          op;
      logic signed [VALUE_W-1:0] val;
      logic [POS_W-1:0]          pos;
      list_rsp                   typed_rsp;
      reset            <= 1'b1;
      req_bus.valid    <= 1'b0;
      req_bus.cmd      <= '0;
      req_bus.value    <= '0;
      req_bus.position <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_table[i]) begin
         typed_rsp.status = dir_table[i].st;
         typed_rsp.count  = dir_table[i].cnt;
         for (int k = 0; k < dir_table[i].reps; k++) begin
            push_command(dir_table[i].op, dir_table[i].val + k, dir_table[i].pos,
                         dir_table[i].typed, typed_rsp);
            pace_sender();
         end
      end
      wait_results_drained();

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         // long receiver hold while commands keep coming
         if (n == 400) rsp_hold_req = 1'b1;
         if (n == 1000) wait_results_drained();
         pick_random_command(op, val, pos);
         push_command(op, val, pos, 1'b0, typed_rsp);
         pace_sender();
      end

      wait_results_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ----- sim.f -----
hdl/ple_pkg.sv
hdl/ple_channels.sv
hdl/ple_ctrl.sv
hdl/ple_dpath.sv
hdl/positional_list_engine.sv
sim/tb_positional_list_engine.sv
